// ===== rtl/core/i2cs_pkg.sv =====
// Shared types, constants and phase tables for the I2C master bit sequencer.
// No dependencies; used by every module under rtl/core.
package i2cs_pkg;

    localparam int COUNTER_BITS_DEF = 16;
    localparam int CFG_W            = 16;
    localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 16'd10;

    // Pin levels are packed as {scl, sda, drive}
    localparam logic [2:0] PINS_IDLE      = 3'b111;
    localparam logic [2:0] PINS_AFT_START = 3'b001;
    localparam logic [2:0] PINS_AFT_STOP  = 3'b111;
    localparam logic [2:0] PINS_AFT_WRITE = 3'b010;

    // Phase of a write in which the acknowledge is sampled
    localparam logic [4:0] WR_ACK_PHASE = 5'd18;
    localparam logic [4:0] DATA_PHASES  = 5'd16;

    typedef enum logic [2:0] {
        OP_START     = 3'd0,
        OP_STOP      = 3'd1,
        OP_WRITE     = 3'd2,
        OP_READ_ACK  = 3'd3,
        OP_READ_NACK = 3'd4
    } t_opcode;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] opcode;
        logic [7:0] wdata;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rdata;
        logic       no_ack;
    } t_result;

    // Control from the step logic to the phase timer
    typedef struct packed {
        logic run;      // a command is active on this tick
        logic restart;  // the command starts on this tick
    } t_tmr_ctl;

    // Number of phases in each command
    function automatic logic [4:0] phase_total(t_opcode cmd);
        logic [4:0] tot;
        unique case (cmd)
            OP_START:    tot = 5'd3;
            OP_STOP:     tot = 5'd4;
            OP_WRITE:    tot = 5'd19;
            OP_READ_ACK: tot = 5'd19;
            default:     tot = 5'd20;
        endcase
        return tot;
    endfunction

    // Pin levels of one phase of a command
    function automatic logic [2:0] phase_levels(t_opcode cmd, logic [4:0] p,
                                                logic [7:0] sb, logic held_sda);
        logic       bitv;
        logic [2:0] lv;
        bitv = sb[3'd7 - p[3:1]];
        lv   = PINS_IDLE;
        unique case (cmd)
            OP_START: begin
                case (p)
                    5'd0:    lv = 3'b111;
                    5'd1:    lv = 3'b101;
                    default: lv = 3'b001;
                endcase
            end
            OP_STOP: begin
                case (p)
                    5'd0:    lv = {1'b0, held_sda, 1'b1};
                    5'd1:    lv = 3'b001;
                    5'd2:    lv = 3'b101;
                    default: lv = 3'b111;
                endcase
            end
            OP_WRITE: begin
                if (p < DATA_PHASES) begin
                    lv = {p[0], bitv, 1'b1};
                end else begin
                    case (p)
                        5'd16:   lv = {1'b0, sb[0], 1'b1};
                        5'd17:   lv = 3'b011;
                        default: lv = 3'b110;
                    endcase
                end
            end
            OP_READ_ACK: begin
                if (p < DATA_PHASES) begin
                    lv = p[0] ? 3'b010 : 3'b110;
                end else begin
                    case (p)
                        5'd17:   lv = 3'b101;
                        default: lv = 3'b001;
                    endcase
                end
            end
            default: begin
                if (p < DATA_PHASES) begin
                    lv = p[0] ? 3'b010 : 3'b110;
                end else begin
                    case (p)
                        5'd18:   lv = 3'b111;
                        default: lv = 3'b011;
                    endcase
                end
            end
        endcase
        return lv;
    endfunction

endpackage

// ===== rtl/core/i2cs_timer.sv =====
// Phase timer: half-period register and tick counter, flags the last tick of a phase.
// Depends on i2cs_pkg.
module i2cs_timer #(
    parameter int COUNTER_BITS = i2cs_pkg::COUNTER_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [i2cs_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                         i_adv,
    input  i2cs_pkg::t_tmr_ctl           i_ctl,
    output logic                         o_phase_end
);

    localparam int CMP_W = (COUNTER_BITS > i2cs_pkg::CFG_W) ? COUNTER_BITS : i2cs_pkg::CFG_W;

    logic [i2cs_pkg::CFG_W-1:0] r_half_period;
    logic [COUNTER_BITS-1:0]    r_tick;
    logic [COUNTER_BITS-1:0]    n_tick;
    logic [COUNTER_BITS-1:0]    tick_cur;
    logic [COUNTER_BITS-1:0]    tick_inc;
    logic [i2cs_pkg::CFG_W-1:0] hp_eff;

    // Count this tick; a phase ends at the half period or when the counter wraps
    always_comb begin
        tick_cur    = i_ctl.restart ? '0 : r_tick;
        tick_inc    = tick_cur + COUNTER_BITS'(1);
        hp_eff      = (r_half_period == '0) ? i2cs_pkg::CFG_W'(1) : r_half_period;
        o_phase_end = (CMP_W'(tick_inc) >= CMP_W'(hp_eff)) || (tick_inc == '0);
        n_tick      = o_phase_end ? '0 : tick_inc;
    end

    // Hold the half period and advance the counter on each active tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= i2cs_pkg::HALF_PERIOD_RST;
            r_tick        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_half_period <= i_cfg_wdata;
            end
            if (i_adv && i_ctl.run) begin
                r_tick <= n_tick;
            end
        end
    end

endmodule

// ===== rtl/core/i2cs_step.sv =====
// Command state and pin sequencing for one tick; builds the result of the tick.
// Depends on i2cs_pkg; pairs with i2cs_timer for phase timing.
module i2cs_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  i2cs_pkg::t_item     i_item,
    input  logic                i_phase_end,
    output i2cs_pkg::t_tmr_ctl  o_tmr,
    output i2cs_pkg::t_result   o_res
);

    logic                r_active;
    i2cs_pkg::t_opcode   r_cmd;
    logic [4:0]          r_phase;
    logic [7:0]          r_shift;
    logic [2:0]          r_pins;
    logic                r_ack_fail;

    logic                n_active;
    i2cs_pkg::t_opcode   n_cmd;
    logic [4:0]          n_phase;
    logic [7:0]          n_shift;
    logic [2:0]          n_pins;
    logic                n_ack_fail;

    logic                start;
    logic                act;
    i2cs_pkg::t_opcode   cmd;
    logic [4:0]          phase;
    logic [4:0]          phase_inc;
    logic [7:0]          shift;
    logic                ackf;
    logic [2:0]          lv;
    logic                is_read;
    logic                finish;

    // Launch a new command only when idle and the opcode is known
    always_comb begin
        start   = !r_active && i_item.cmd_valid &&
                  (i_item.opcode <= 3'(i2cs_pkg::OP_READ_NACK));
        act     = r_active || start;
        cmd     = start ? i2cs_pkg::t_opcode'(i_item.opcode) : r_cmd;
        phase   = start ? 5'd0 : r_phase;
        shift   = start ? ((i_item.opcode == 3'(i2cs_pkg::OP_WRITE)) ? i_item.wdata : 8'd0)
                        : r_shift;
        ackf    = start ? 1'b0 : r_ack_fail;
        is_read = (cmd == i2cs_pkg::OP_READ_ACK) || (cmd == i2cs_pkg::OP_READ_NACK);
        lv      = i2cs_pkg::phase_levels(cmd, phase, shift, r_pins[1]);
        o_tmr.run     = act;
        o_tmr.restart = start;
    end

    // Advance phase, sample the bus and build the result of this tick
    always_comb begin
        n_active   = r_active;
        n_cmd      = cmd;
        n_phase    = phase;
        n_shift    = shift;
        n_pins     = r_pins;
        n_ack_fail = ackf;
        phase_inc  = phase + 5'd1;
        finish     = 1'b0;
        o_res      = '0;
        o_res.scl_out   = r_pins[2];
        o_res.sda_out   = r_pins[1];
        o_res.sda_drive = r_pins[0];
        if (act) begin
            n_active        = 1'b1;
            n_pins          = lv;
            o_res.scl_out   = lv[2];
            o_res.sda_out   = lv[1];
            o_res.sda_drive = lv[0];
            o_res.busy_res  = 1'b1;
            if (i_phase_end) begin
                if (cmd == i2cs_pkg::OP_WRITE && phase == i2cs_pkg::WR_ACK_PHASE) begin
                    n_ack_fail = i_item.sda_in;
                end
                if (is_read && phase < i2cs_pkg::DATA_PHASES && !phase[0]) begin
                    n_shift = {shift[6:0], i_item.sda_in};
                end
                n_phase = phase_inc;
                finish  = phase_inc >= i2cs_pkg::phase_total(cmd);
            end
            if (finish) begin
                o_res.done_res = 1'b1;
                n_active       = 1'b0;
                n_phase        = 5'd0;
                case (cmd)
                    i2cs_pkg::OP_START: n_pins = i2cs_pkg::PINS_AFT_START;
                    i2cs_pkg::OP_STOP:  n_pins = i2cs_pkg::PINS_AFT_STOP;
                    i2cs_pkg::OP_WRITE: begin
                        n_pins       = i2cs_pkg::PINS_AFT_WRITE;
                        o_res.no_ack = n_ack_fail;
                    end
                    default: o_res.rdata = n_shift;
                endcase
            end
        end
    end

    // Commit the command state when the tick moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_cmd      <= i2cs_pkg::OP_START;
            r_phase    <= 5'd0;
            r_shift    <= 8'd0;
            r_pins     <= i2cs_pkg::PINS_IDLE;
            r_ack_fail <= 1'b0;
        end else if (i_adv) begin
            r_active   <= n_active;
            r_cmd      <= n_cmd;
            r_phase    <= n_phase;
            r_shift    <= n_shift;
            r_pins     <= n_pins;
            r_ack_fail <= n_ack_fail;
        end
    end

endmodule

// ===== rtl/core/i2c_master_bit_sequencer_core.sv =====
// Top level of the I2C master bit sequencer: input register, step logic, result register.
// Depends on i2cs_pkg, i2cs_timer and i2cs_step.
//
//   channel | handshake                   | payload
//   in      | i_in_valid / o_in_stall     | i_cmd_valid i_opcode i_wdata i_sda_in
//   out     | o_out_valid / i_out_stall   | o_scl_out o_sda_out o_sda_drive o_busy_res
//           |                             | o_done_res o_rdata o_no_ack
//   cfg     | i_cfg_we                    | i_cfg_wdata (half period)
//
// One tick per clock while the output is not stalled: a transfer is held in the input register
// and its result is then registered in the result register.
// The step logic and phase timer lie between the two registers.
// Synchronous active-low reset clears the command state and valids and sets the half period to 10.
// A stall on the output holds the result and, through the input register, the input.
module i2c_master_bit_sequencer_core #(
    parameter int COUNTER_BITS = i2cs_pkg::COUNTER_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [i2cs_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_cmd_valid,
    input  logic [2:0]                 i_opcode,
    input  logic [7:0]                 i_wdata,
    input  logic                       i_sda_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_scl_out,
    output logic                       o_sda_out,
    output logic                       o_sda_drive,
    output logic                       o_busy_res,
    output logic                       o_done_res,
    output logic [7:0]                 o_rdata,
    output logic                       o_no_ack
);

    logic                r_in_valid;
    i2cs_pkg::t_item     r_item;
    logic                r_out_valid;
    i2cs_pkg::t_result   r_res;

    logic                adv;
    logic                in_take;
    logic                phase_end;
    i2cs_pkg::t_tmr_ctl  tmr_ctl;
    i2cs_pkg::t_result   res;

    // Handshake: advance when the result register is free or being drained
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    // Capture an incoming transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.cmd_valid <= i_cmd_valid;
            r_item.opcode    <= i_opcode;
            r_item.wdata     <= i_wdata;
            r_item.sda_in    <= i_sda_in;
        end
    end

    i2cs_timer #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_timer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (adv),
        .i_ctl       (tmr_ctl),
        .o_phase_end (phase_end)
    );

    i2cs_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_item      (r_item),
        .i_phase_end (phase_end),
        .o_tmr       (tmr_ctl),
        .o_res       (res)
    );

    // Hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_out   = r_res.scl_out;
    assign o_sda_out   = r_res.sda_out;
    assign o_sda_drive = r_res.sda_drive;
    assign o_busy_res  = r_res.busy_res;
    assign o_done_res  = r_res.done_res;
    assign o_rdata     = r_res.rdata;
    assign o_no_ack    = r_res.no_ack;

    // A completed command is always reported as a busy tick
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> o_busy_res)
        else $error("done without busy");

    // Read byte and ack failure appear only on a done tick
    a_result_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_done_res |-> (o_rdata == 8'd0) && !o_no_ack)
        else $error("result field outside done tick");

    // Input stalls only while a held result is blocked downstream
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // A stalled input transfer stays in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_valid && $stable(r_item))
        else $error("input register lost a stalled transfer");

endmodule
